/* rtl/core/hfs_pkg.sv */
// ----------------------------------------------------------------------------
// hfs_pkg
// Shared types, codes and byte helpers for the HTTP/2 frame serializer.
// ----------------------------------------------------------------------------
package hfs_pkg;

    localparam int MAX_RES   = 17;
    localparam int CNT_W     = 5;
    localparam int HDR_BYTES = 9;

    localparam logic [23:0] MIN_FRAME = 24'd16384;
    localparam logic [7:0]  FLAG_END  = 8'h01;

    localparam logic [3:0] KIND_DATA     = 4'd0;
    localparam logic [3:0] KIND_BYTE     = 4'd1;
    localparam logic [3:0] KIND_PRIORITY = 4'd2;
    localparam logic [3:0] KIND_RST      = 4'd3;
    localparam logic [3:0] KIND_SETTINGS = 4'd4;
    localparam logic [3:0] KIND_ENTRY    = 4'd5;
    localparam logic [3:0] KIND_SET_ACK  = 4'd6;
    localparam logic [3:0] KIND_PING     = 4'd7;
    localparam logic [3:0] KIND_WINDOW   = 4'd8;
    localparam logic [3:0] KIND_GOAWAY   = 4'd9;

    localparam logic [7:0] FT_DATA     = 8'd0;
    localparam logic [7:0] FT_PRIORITY = 8'd2;
    localparam logic [7:0] FT_RST      = 8'd3;
    localparam logic [7:0] FT_SETTINGS = 8'd4;
    localparam logic [7:0] FT_PING     = 8'd6;
    localparam logic [7:0] FT_GOAWAY   = 8'd7;
    localparam logic [7:0] FT_WINDOW   = 8'd8;

    localparam logic [23:0] LEN_PRIORITY = 24'd5;
    localparam logic [23:0] LEN_WORD     = 24'd4;
    localparam logic [23:0] LEN_PING     = 24'd8;
    localparam logic [23:0] LEN_GOAWAY   = 24'd8;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_DATA     = 2'd1,
        MODE_SETTINGS = 2'd2,
        MODE_GOAWAY   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [MAX_RES-1:0]      fe;
        logic [CNT_W-1:0]        count;
        logic [1:0]              status;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [HDR_BYTES-1:0][7:0] hdr(
        input logic [23:0] len,
        input logic [7:0]  typ,
        input logic [7:0]  flg,
        input logic [30:0] sid
    );
        logic [HDR_BYTES-1:0][7:0] h;
        h[0] = len[23:16];
        h[1] = len[15:8];
        h[2] = len[7:0];
        h[3] = typ;
        h[4] = flg;
        h[5] = {1'b0, sid[30:24]};
        h[6] = sid[23:16];
        h[7] = sid[15:8];
        h[8] = sid[7:0];
        return h;
    endfunction

    function automatic logic [3:0][7:0] be32(input logic [31:0] w);
        logic [3:0][7:0] b;
        b[0] = w[31:24];
        b[1] = w[23:16];
        b[2] = w[15:8];
        b[3] = w[7:0];
        return b;
    endfunction

endpackage

/* rtl/core/hfs_channels.sv */
// ----------------------------------------------------------------------------
// hfs_channels
// Valid/ready channels for input requests and serialized result bytes.
// ----------------------------------------------------------------------------
interface hfs_item_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [30:0] stream_id;
    logic        flag;
    logic [31:0] length;
    logic [31:0] word;
    logic [8:0]  weight;
    logic [15:0] setting_id;
    logic [63:0] ping_data;
    logic [7:0]  byte_value;

    modport source (
        output valid, kind, stream_id, flag, length, word, weight, setting_id,
               ping_data, byte_value,
        input  ready
    );
    modport sink (
        input  valid, kind, stream_id, flag, length, word, weight, setting_id,
               ping_data, byte_value,
        output ready
    );
endinterface

interface hfs_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       item_end;
    logic [1:0] status;

    modport source (
        output valid, out_byte, frame_end, item_end, status,
        input  ready
    );
    modport sink (
        input  valid, out_byte, frame_end, item_end, status,
        output ready
    );
endinterface

/* rtl/core/http2_frame_serializer_unit.sv */
// ----------------------------------------------------------------------------
// http2_frame_serializer_unit
// HTTP/2 frame serializer: requests in, big-endian frame bytes out.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while its job queue (QUEUE_DEPTH
// entries) has room, and sends one result byte per cycle while the result
// channel is ready. A request yields one result byte for a payload byte or
// a dropped or ignored request, six for a settings entry, nine for a bare
// header (data start, settings start, settings ack), ten for a payload byte
// that closes a data frame and opens the next, thirteen for reset stream and
// window update, fourteen for priority and seventeen for ping and goaway.
// The single-byte output stage sets the sustained rate; data payload streams
// at one byte per cycle while the result channel is ready.
module http2_frame_serializer_unit
    import hfs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    hfs_item_if.sink     items,
    hfs_result_if.source results,
    input  logic         cfg_wr_en,
    input  logic [23:0]  cfg_wr_data
);

    logic    push;
    logic    pop;
    job_t    push_job;
    job_t    head;
    q_stat_t qstat;

    hfs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .items       (items),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .qstat       (qstat),
        .push        (push),
        .job         (push_job)
    );

    hfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    hfs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .qstat   (qstat),
        .pop     (pop),
        .results (results)
    );

endmodule

/* rtl/core/hfs_front.sv */
// ----------------------------------------------------------------------------
// hfs_front
// Accepts requests, tracks payload state and builds one byte job per request.
// ----------------------------------------------------------------------------
module hfs_front
    import hfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    hfs_item_if.sink    items,
    input  logic        cfg_wr_en,
    input  logic [23:0] cfg_wr_data,
    input  q_stat_t     qstat,
    output logic        push,
    output job_t        job
);

    mode_t       mode_reg, mode_next;
    logic [31:0] total_reg, total_next;
    logic [23:0] frame_reg, frame_next;
    logic [30:0] stream_reg, stream_next;
    logic        pend_reg, pend_next;
    logic [23:0] mfs_reg;

    logic        accept;
    logic [31:0] total_dec;
    logic [23:0] frame_dec;
    logic [23:0] next_chunk;
    logic [23:0] start_chunk;
    logic [34:0] set_len;
    logic        set_over;
    logic [23:0] gw_lim;
    logic [23:0] gw_dbg;
    logic        next_end;
    logic        start_end;

    assign items.ready = !qstat.full;
    assign accept      = items.valid && items.ready;
    assign push        = accept;

    assign total_dec   = total_reg - 32'd1;
    assign frame_dec   = frame_reg - 24'd1;
    assign next_chunk  = (total_dec < {8'd0, mfs_reg}) ? total_dec[23:0] : mfs_reg;
    assign next_end    = pend_reg && ({8'd0, next_chunk} == total_dec);
    assign start_chunk = (items.length < {8'd0, mfs_reg}) ? items.length[23:0] : mfs_reg;
    assign start_end   = items.flag && ({8'd0, start_chunk} == items.length);
    assign set_len     = ({3'd0, items.length} << 2) + ({3'd0, items.length} << 1);
    assign set_over    = set_len > {11'd0, mfs_reg};
    assign gw_lim      = mfs_reg - LEN_GOAWAY;
    assign gw_dbg      = (items.length < {8'd0, gw_lim}) ? items.length[23:0] : gw_lim;

    always_comb
    begin
        mode_next = mode_reg;
        unique case (mode_reg)
            MODE_IDLE:
            begin
                unique case (items.kind)
                    KIND_DATA:     if (start_chunk != 24'd0) mode_next = MODE_DATA;
                    KIND_SETTINGS:
                        if (!set_over && items.length != 32'd0) mode_next = MODE_SETTINGS;
                    KIND_GOAWAY:   if (items.length != 32'd0) mode_next = MODE_GOAWAY;
                    default:       mode_next = MODE_IDLE;
                endcase
            end
            MODE_SETTINGS:
                if (items.kind == KIND_ENTRY && total_dec == 32'd0) mode_next = MODE_IDLE;
            MODE_DATA, MODE_GOAWAY:
                if (items.kind == KIND_BYTE && total_dec == 32'd0) mode_next = MODE_IDLE;
            default: mode_next = MODE_IDLE;
        endcase
    end

    always_comb
    begin
        total_next  = total_reg;
        frame_next  = frame_reg;
        stream_next = stream_reg;
        pend_next   = pend_reg;
        job         = '0;
        job.count   = CNT_W'(1);
        job.status  = ST_OK;
        unique case (mode_reg)
            MODE_IDLE:
            begin
                unique case (items.kind)
                    KIND_DATA:
                    begin
                        stream_next   = items.stream_id;
                        pend_next     = items.flag;
                        total_next    = items.length;
                        frame_next    = start_chunk;
                        job.bytes[8:0] = hdr(start_chunk, FT_DATA,
                                             start_end ? FLAG_END : 8'd0, items.stream_id);
                        job.count     = CNT_W'(9);
                        job.fe[8]     = (start_chunk == 24'd0);
                    end
                    KIND_PRIORITY:
                    begin
                        job.bytes[8:0]  = hdr(LEN_PRIORITY, FT_PRIORITY, 8'd0,
                                              items.stream_id);
                        job.bytes[12:9] = be32({items.flag, items.word[30:0]});
                        job.bytes[13]   = items.weight[7:0] - 8'd1;
                        job.count       = CNT_W'(14);
                        job.fe[13]      = 1'b1;
                    end
                    KIND_RST:
                    begin
                        job.bytes[8:0]  = hdr(LEN_WORD, FT_RST, 8'd0, items.stream_id);
                        job.bytes[12:9] = be32(items.word);
                        job.count       = CNT_W'(13);
                        job.fe[12]      = 1'b1;
                    end
                    KIND_SETTINGS:
                    begin
                        if (set_over)
                        begin
                            job.status = ST_IGNORED;
                        end
                        else
                        begin
                            total_next     = items.length;
                            job.bytes[8:0] = hdr(set_len[23:0], FT_SETTINGS, 8'd0, 31'd0);
                            job.count      = CNT_W'(9);
                            job.fe[8]      = (items.length == 32'd0);
                        end
                    end
                    KIND_SET_ACK:
                    begin
                        job.bytes[8:0] = hdr(24'd0, FT_SETTINGS, FLAG_END, 31'd0);
                        job.count      = CNT_W'(9);
                        job.fe[8]      = 1'b1;
                    end
                    KIND_PING:
                    begin
                        job.bytes[8:0]   = hdr(LEN_PING, FT_PING,
                                               items.flag ? FLAG_END : 8'd0, 31'd0);
                        job.bytes[12:9]  = be32(items.ping_data[63:32]);
                        job.bytes[16:13] = be32(items.ping_data[31:0]);
                        job.count        = CNT_W'(17);
                        job.fe[16]       = 1'b1;
                    end
                    KIND_WINDOW:
                    begin
                        job.bytes[8:0]  = hdr(LEN_WORD, FT_WINDOW, 8'd0, items.stream_id);
                        job.bytes[12:9] = be32({1'b0, items.word[30:0]});
                        job.count       = CNT_W'(13);
                        job.fe[12]      = 1'b1;
                    end
                    KIND_GOAWAY:
                    begin
                        total_next       = items.length;
                        frame_next       = gw_dbg;
                        job.bytes[8:0]   = hdr(gw_dbg + LEN_GOAWAY, FT_GOAWAY, 8'd0, 31'd0);
                        job.bytes[12:9]  = be32({1'b0, items.stream_id});
                        job.bytes[16:13] = be32(items.word);
                        job.count        = CNT_W'(17);
                        job.fe[16]       = (gw_dbg == 24'd0);
                    end
                    default: job.status = ST_IGNORED;
                endcase
            end
            MODE_SETTINGS:
            begin
                if (items.kind != KIND_ENTRY)
                begin
                    job.status = ST_IGNORED;
                end
                else
                begin
                    total_next     = total_dec;
                    job.bytes[0]   = items.setting_id[15:8];
                    job.bytes[1]   = items.setting_id[7:0];
                    job.bytes[5:2] = be32(items.word);
                    job.count      = CNT_W'(6);
                    job.fe[5]      = (total_dec == 32'd0);
                end
            end
            MODE_GOAWAY:
            begin
                if (items.kind != KIND_BYTE)
                begin
                    job.status = ST_IGNORED;
                end
                else
                begin
                    total_next = total_dec;
                    if (frame_reg == 24'd0)
                    begin
                        job.status = ST_DROPPED;
                    end
                    else
                    begin
                        frame_next   = frame_dec;
                        job.bytes[0] = items.byte_value;
                        job.fe[0]    = (frame_dec == 24'd0);
                    end
                end
            end
            MODE_DATA:
            begin
                if (items.kind != KIND_BYTE)
                begin
                    job.status = ST_IGNORED;
                end
                else
                begin
                    total_next   = total_dec;
                    frame_next   = frame_dec;
                    job.bytes[0] = items.byte_value;
                    if (frame_dec == 24'd0)
                    begin
                        job.fe[0] = 1'b1;
                        if (total_dec != 32'd0)
                        begin
                            frame_next      = next_chunk;
                            job.bytes[9:1]  = hdr(next_chunk, FT_DATA,
                                                  next_end ? FLAG_END : 8'd0, stream_reg);
                            job.count       = CNT_W'(10);
                        end
                    end
                end
            end
            default: job.status = ST_IGNORED;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            total_reg  <= '0;
            frame_reg  <= '0;
            stream_reg <= '0;
            pend_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            total_reg  <= total_next;
            frame_reg  <= frame_next;
            stream_reg <= stream_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mfs_reg <= MIN_FRAME;
        end
        else if (cfg_wr_en)
        begin
            mfs_reg <= (cfg_wr_data < MIN_FRAME) ? MIN_FRAME : cfg_wr_data;
        end
    end

endmodule

/* rtl/core/hfs_queue.sv */
// ----------------------------------------------------------------------------
// hfs_queue
// Short job queue between the request front end and the byte back end.
// ----------------------------------------------------------------------------
module hfs_queue
    import hfs_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    head,
    output q_stat_t qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    job_t              slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] fill_reg, fill_next;

    assign head        = slot_reg[rd_ptr_reg];
    assign qstat.full  = (fill_reg == CNT_QW'(DEPTH));
    assign qstat.empty = (fill_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + CNT_QW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* rtl/core/hfs_back.sv */
// ----------------------------------------------------------------------------
// hfs_back
// Walks the head job into registered results, one byte per unstalled cycle.
// ----------------------------------------------------------------------------
module hfs_back
    import hfs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  job_t         head,
    input  q_stat_t      qstat,
    output logic         pop,
    hfs_result_if.source results
);

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg;
    logic             fe_reg;
    logic             end_reg;
    logic [1:0]       status_reg;
    logic             load;
    logic             last;

    assign load = !valid_reg || results.ready;
    assign last = (idx_reg == head.count - CNT_W'(1));
    assign pop  = load && !qstat.empty && last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = !qstat.empty;
            if (!qstat.empty)
            begin
                idx_next = last ? '0 : idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !qstat.empty)
        begin
            byte_reg   <= head.bytes[idx_reg];
            fe_reg     <= head.fe[idx_reg];
            end_reg    <= last;
            status_reg <= head.status;
        end
    end

    assign results.valid     = valid_reg;
    assign results.out_byte  = byte_reg;
    assign results.frame_end = fe_reg;
    assign results.item_end  = end_reg;
    assign results.status    = status_reg;

endmodule
